[rtl/core/mgceb_pkg.sv]
// Shared types and constants for the monochrome glyph color-expansion blit.
package mgceb_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int SURF_W      = 13;
  localparam int GLYPH_W     = 11;
  localparam int COLOR_W     = 24;
  localparam int ADDR_W      = 24;
  localparam int CMP_W       = 16;
  localparam int LANES       = 8;
  localparam int LANE_IDX_W  = 3;

  localparam logic [SURF_W-1:0]  SURFACE_WIDTH_RST  = 13'd512;
  localparam logic [SURF_W-1:0]  SURFACE_HEIGHT_RST = 13'd256;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST     = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_ORIGIN_X       = 3'd2,
    REG_ORIGIN_Y       = 3'd3,
    REG_GLYPH_WIDTH    = 3'd4,
    REG_GLYPH_HEIGHT   = 3'd5,
    REG_FILL_COLOR     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LANES-1:0]   mask;
    logic [ADDR_W-1:0]  row_base;
    logic [CMP_W-1:0]   x0;
    logic [COLOR_W-1:0] color;
  } work_t;

endpackage

[rtl/core/mgceb_emit.sv]
// Pixel write sequencer: holds one expanded byte and issues its writes one per cycle while out_stall is low.
module mgceb_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load_valid,
  input  mgceb_pkg::work_t                  load_word,
  output logic                              load_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mgceb_pkg::ADDR_W-1:0]      out_pixel_address,
  output logic [mgceb_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                              out_last_of_byte
);
  import mgceb_pkg::*;

  logic                  work_valid_r;
  work_t                 work_r;
  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  fire;
  logic [LANE_IDX_W-1:0] pick_idx;
  logic [LANES-1:0]      pick_hot;
  logic [LANES-1:0]      rest_mask;
  logic                  pick_last;
  logic [CMP_W-1:0]      dx;
  logic [ADDR_W-1:0]     addr_nxt;

  always_comb begin
    pick_idx = '0;
    pick_hot = '0;
    for (int b = LANES - 1; b >= 0; b--) begin
      if (work_r.mask[b]) begin
        pick_idx = LANE_IDX_W'(b);
        pick_hot = LANES'(1) << b;
      end
    end
  end

  assign rest_mask  = work_r.mask & ~pick_hot;
  assign pick_last  = (rest_mask == '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign fire       = work_valid_r && out_free;
  assign load_ready = !work_valid_r || (fire && pick_last);
  assign dx         = work_r.x0 + CMP_W'(pick_idx);
  assign addr_nxt   = work_r.row_base + ADDR_W'(dx[SURF_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
    end else if (load_valid && load_ready) begin
      work_valid_r <= 1'b1;
    end else if (fire && pick_last) begin
      work_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      work_r <= load_word;
    end else if (fire) begin
      work_r.mask <= rest_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_addr_r  <= addr_nxt;
      out_color_r <= work_r.color;
      out_last_r  <= pick_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_of_byte  = out_last_r;

endmodule

[rtl/core/mono_glyph_color_expand_blit.sv]
// Top level of the monochrome glyph color-expansion blit with clipping.
// Each accepted bitmap word is clipped and expanded combinationally into a mask of up to eight
// pixel writes plus a row base address (one 13 by 13 multiply), then the write sequencer
// issues one pixel write per cycle from its output register while out_stall is low. A word
// that yields several writes occupies the sequencer until its last write issues; a word with
// no writes, or one taken while the glyph is empty, is not loaded into the sequencer. The
// next word is accepted in the cycle its predecessor issues its last write. A first write
// passes the work register, then the output register. The configuration port is
// always ready and is to be written only while no words are in flight.
module mono_glyph_color_expand_blit #(
  parameter int MAX_SURFACE_DIM = 4096,
  parameter int MAX_GLYPH_DIM   = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_glyph_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mgceb_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [mgceb_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                               out_last_of_byte,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mgceb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mgceb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mgceb_pkg::*;

  localparam int STRIDE_MAX = (MAX_GLYPH_DIM + 7) / 8;
  localparam int COL_W      = (STRIDE_MAX > 1) ? $clog2(STRIDE_MAX) : 1;
  localparam int ROW_W      = (MAX_GLYPH_DIM > 1) ? $clog2(MAX_GLYPH_DIM) : 1;
  localparam int SURF_CAP   = (MAX_SURFACE_DIM > 8191) ? 8191 : MAX_SURFACE_DIM;
  localparam int GLYPH_CAP  = (MAX_GLYPH_DIM > 2047) ? 2047 : MAX_GLYPH_DIM;
  localparam logic [SURF_W-1:0]  SURF_MAX  = SURF_W'(SURF_CAP);
  localparam logic [GLYPH_W-1:0] GLYPH_MAX = GLYPH_W'(GLYPH_CAP);

  logic [SURF_W-1:0]  surface_width_r;
  logic [SURF_W-1:0]  surface_height_r;
  logic [SURF_W-1:0]  origin_x_r;
  logic [SURF_W-1:0]  origin_y_r;
  logic [GLYPH_W-1:0] glyph_width_r;
  logic [GLYPH_W-1:0] glyph_height_r;
  logic [COLOR_W-1:0] fill_color_r;

  logic [COL_W-1:0]   byte_column_r;
  logic [COL_W-1:0]   byte_column_nxt;
  logic [ROW_W-1:0]   glyph_row_r;
  logic [ROW_W-1:0]   glyph_row_nxt;

  logic [GLYPH_W-1:0] gw;
  logic [GLYPH_W-1:0] gh;
  logic [SURF_W-1:0]  sw;
  logic [SURF_W-1:0]  sh;
  logic               glyph_empty;
  logic [CMP_W-1:0]   stride;
  logic               row_ok;
  logic [CMP_W-1:0]   dy;
  logic               dy_ok;
  logic [CMP_W-1:0]   col_base;
  logic [CMP_W-1:0]   x0;
  logic [CMP_W-1:0]   col_b;
  logic [CMP_W-1:0]   dx_b;
  logic [LANES-1:0]   mask;
  logic [2*SURF_W-1:0] row_prod;
  logic               accept;
  logic               load_valid;
  logic               load_ready;
  work_t              load_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= SURFACE_WIDTH_RST;
      surface_height_r <= SURFACE_HEIGHT_RST;
      origin_x_r       <= '0;
      origin_y_r       <= '0;
      glyph_width_r    <= '0;
      glyph_height_r   <= '0;
      fill_color_r     <= FILL_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SURFACE_WIDTH:  surface_width_r  <= cfg_data[SURF_W-1:0];
        REG_SURFACE_HEIGHT: surface_height_r <= cfg_data[SURF_W-1:0];
        REG_ORIGIN_X:       origin_x_r       <= cfg_data[SURF_W-1:0];
        REG_ORIGIN_Y:       origin_y_r       <= cfg_data[SURF_W-1:0];
        REG_GLYPH_WIDTH:    glyph_width_r    <= cfg_data[GLYPH_W-1:0];
        REG_GLYPH_HEIGHT:   glyph_height_r   <= cfg_data[GLYPH_W-1:0];
        REG_FILL_COLOR:     fill_color_r     <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign gw = (glyph_width_r > GLYPH_MAX) ? GLYPH_MAX : glyph_width_r;
  assign gh = (glyph_height_r > GLYPH_MAX) ? GLYPH_MAX : glyph_height_r;
  assign sw = (surface_width_r > SURF_MAX) ? SURF_MAX : surface_width_r;
  assign sh = (surface_height_r > SURF_MAX) ? SURF_MAX : surface_height_r;

  assign glyph_empty = (gw == '0) || (gh == '0);
  assign stride      = (CMP_W'(gw) + CMP_W'(7)) >> 3;
  assign row_ok      = CMP_W'(glyph_row_r) < CMP_W'(gh);
  assign dy          = {{(CMP_W-SURF_W){origin_y_r[SURF_W-1]}}, origin_y_r}
                       + CMP_W'(glyph_row_r);
  assign dy_ok       = !dy[CMP_W-1] && (dy < CMP_W'(sh));
  assign col_base    = CMP_W'(byte_column_r) << 3;
  assign x0          = {{(CMP_W-SURF_W){origin_x_r[SURF_W-1]}}, origin_x_r} + col_base;

  always_comb begin
    mask  = '0;
    col_b = '0;
    dx_b  = '0;
    for (int b = 0; b < LANES; b++) begin
      col_b   = col_base + CMP_W'(b);
      dx_b    = x0 + CMP_W'(b);
      mask[b] = in_glyph_byte[LANES-1-b] && (col_b < CMP_W'(gw))
                && !dx_b[CMP_W-1] && (dx_b < CMP_W'(sw));
    end
    mask = mask & {LANES{row_ok && dy_ok}};
  end

  assign row_prod = dy[SURF_W-1:0] * sw;

  assign in_stall   = !load_ready;
  assign accept     = in_valid && !in_stall;
  assign load_valid = accept && !glyph_empty && (mask != '0);

  assign load_word.mask     = mask;
  assign load_word.row_base = row_prod[ADDR_W-1:0];
  assign load_word.x0       = x0;
  assign load_word.color    = fill_color_r;

  always_comb begin
    byte_column_nxt = byte_column_r;
    glyph_row_nxt   = glyph_row_r;
    if (!row_ok) begin
      byte_column_nxt = '0;
      glyph_row_nxt   = '0;
    end else if (CMP_W'(byte_column_r) + CMP_W'(1) >= stride) begin
      byte_column_nxt = '0;
      if (CMP_W'(glyph_row_r) + CMP_W'(1) >= CMP_W'(gh)) begin
        glyph_row_nxt = '0;
      end else begin
        glyph_row_nxt = glyph_row_r + ROW_W'(1);
      end
    end else begin
      byte_column_nxt = byte_column_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= '0;
      glyph_row_r   <= '0;
    end else if (accept && !glyph_empty) begin
      byte_column_r <= byte_column_nxt;
      glyph_row_r   <= glyph_row_nxt;
    end
  end

  mgceb_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_valid        (load_valid),
    .load_word         (load_word),
    .load_ready        (load_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_byte  (out_last_of_byte)
  );

endmodule
